FILE: hdl/puct_pkg.sv
// shared types, widths and codes of the puct child selector
// no dependencies
package puct_pkg;

    localparam int NUM_CHILDREN_DEF = 64;

    localparam int IDX_W   = 6;
    localparam int MASK_W  = 64;
    localparam int GAIN_W  = 16;
    localparam int PRIOR_W = 16;
    localparam int LEAF_W  = 16;
    localparam int VISIT_W = 20;
    localparam int SUM_W   = 32;
    localparam int NODE_W  = 26;
    localparam int SQRT_W  = 29;
    localparam int X_W     = NODE_W + 32;
    localparam int PROD1_W = GAIN_W + PRIOR_W;
    localparam int PROD_W  = PROD1_W + SQRT_W;
    localparam int EXPL_W  = PROD_W - 28;
    localparam int DIV_NUM_W = 34;
    localparam int DIV_DEN_W = VISIT_W + 1;
    localparam int SCORE_W = 36;
    localparam int ROW_W   = VISIT_W + SUM_W;

    localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd4096;
    localparam logic [SQRT_W-1:0]  SQRT_ZERO  = 29'd7;
    localparam logic [VISIT_W-1:0] VISIT_MAX  = '1;
    localparam logic [NODE_W-1:0]  NODE_MAX   = '1;
    localparam int ONE_Q14 = 16384;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_SELECT = 2'd1;
    localparam logic [1:0] CMD_BACKUP = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_EXP   = 2'd1;
    localparam logic [1:0] STATUS_NO_VALID  = 2'd2;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
        logic [DIV_DEN_W-1:0] rem;
    } div_rsp_t;

endpackage

FILE: hdl/puct_if.sv
// valid/ready channel interfaces of the puct child selector
// depends on puct_pkg
interface puct_req_if;
    import puct_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [IDX_W-1:0]   child_index;
    logic [PRIOR_W-1:0] prior_value;
    logic               prior_last;
    logic signed [LEAF_W-1:0] leaf_value;
    logic [MASK_W-1:0]  valid_mask;
    modport source (output valid, cmd, child_index, prior_value, prior_last, leaf_value,
                    valid_mask, input ready);
    modport sink (input valid, cmd, child_index, prior_value, prior_last, leaf_value,
                  valid_mask, output ready);
endinterface

interface puct_rsp_if;
    import puct_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] chosen_child;
    logic [1:0]       status;
    modport source (output valid, chosen_child, status, input ready);
    modport sink (input valid, chosen_child, status, output ready);
endinterface

interface puct_cfg_if;
    import puct_pkg::*;
    logic              valid;
    logic              ready;
    logic [GAIN_W-1:0] exploration_gain;
    modport source (output valid, exploration_gain, input ready);
    modport sink (input valid, exploration_gain, output ready);
endinterface

FILE: hdl/puct_divu.sv
// shared restoring divider, one quotient bit per cycle
// depends on puct_pkg
module puct_divu
    import puct_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg, done_reg;
    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   trial;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[DIV_NUM_W-1]};
        trial  = rem_sh - {1'b0, den_reg};
        if (rem_sh >= {1'b0, den_reg})
        begin
            rem_next = trial[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            quo_reg <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

FILE: hdl/puct_child_selector.sv
// puct child selector top level: child tables, sequencer, square root and scoring
// depends on puct_pkg, puct_if and puct_divu
//
// request channel carries load prior, select child and backpropagate commands;
// result channel returns one item (chosen_child, status) per accepted request;
// cfg channel writes exploration_gain (always ready); the user is to write it
// only while the block is idle, which the block itself does not enforce.
// one request is in work at a time; request.ready is low until its result is
// placed in the output register, which holds it while result.ready is low.
// load, unused command and select with an error: accept, then finish.
// backpropagate: accept, table read, write back, finish.
// select: accept, the 29-step square root of the node count, a scan step over
// every child, and per legal child fetch, multiply and the explore division, then
// the value division when the child has visits, both on the one shared serial
// divider, and a score step; then update the winner and finish. the finish state
// waits while the output register holds an unread result.
// reset clears all visit counts, value sums, node count and expanded flag at
// once (per-child valid bits) and sets exploration_gain to 1.0; priors are
// undefined until loaded.
module puct_child_selector
    import puct_pkg::*;
#(
    parameter int NUM_CHILDREN = NUM_CHILDREN_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    puct_cfg_if.sink   cfg,
    puct_req_if.sink   request,
    puct_rsp_if.source result
);
    localparam int CW = (NUM_CHILDREN > 1) ? $clog2(NUM_CHILDREN) : 1;
    localparam int SQ_CNT_W = $clog2(SQRT_W);

    typedef enum logic [14:0] {
        ST_IDLE    = 15'b000000000000001,
        ST_BP_RD   = 15'b000000000000010,
        ST_BP_WR   = 15'b000000000000100,
        ST_SQRT    = 15'b000000000001000,
        ST_SCAN    = 15'b000000000010000,
        ST_FETCH   = 15'b000000000100000,
        ST_MUL     = 15'b000000001000000,
        ST_DIV1_GO = 15'b000000010000000,
        ST_DIV1    = 15'b000000100000000,
        ST_DIV2_GO = 15'b000001000000000,
        ST_DIV2    = 15'b000010000000000,
        ST_SCORE   = 15'b000100000000000,
        ST_UPD_RD  = 15'b001000000000000,
        ST_UPD_WR  = 15'b010000000000000,
        ST_FINISH  = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [GAIN_W-1:0]        gain_reg;
    logic                     expanded_reg;
    logic [NODE_W-1:0]        nv_reg;
    logic [NUM_CHILDREN-1:0]  row_valid_reg;

    logic [IDX_W-1:0]         idx_reg;
    logic signed [LEAF_W-1:0] leaf_reg;
    logic [NUM_CHILDREN-1:0]  mask_reg;

    logic [ROW_W-1:0]   row_mem [NUM_CHILDREN];
    logic [PRIOR_W-1:0] prior_mem [NUM_CHILDREN];
    logic [ROW_W-1:0]   row_q_reg;
    logic               row_vq_reg;
    logic [PRIOR_W-1:0] prior_q_reg;
    logic [CW-1:0]      rd_addr;
    logic               row_we;
    logic [CW-1:0]      row_wa;
    logic [ROW_W-1:0]   row_wd;
    logic               prior_we;

    logic [X_W-1:0]     sq_x_reg;
    logic [SQRT_W+1:0]  sq_rem_reg;
    logic [SQRT_W-1:0]  sq_res_reg;
    logic [SQ_CNT_W-1:0] sq_cnt_reg;
    logic [SQRT_W-1:0]  s_reg;
    logic [SQRT_W+3:0]  sq_rem_sh;
    logic [SQRT_W+3:0]  sq_trial;
    logic [SQRT_W+1:0]  sq_rem_next;
    logic [SQRT_W-1:0]  sq_res_next;

    logic [CW-1:0]              scan_reg;
    logic [CW-1:0]              best_reg;
    logic signed [SCORE_W-1:0]  best_score_reg;
    logic                       found_reg;
    logic [VISIT_W-1:0]         n_reg;
    logic signed [SUM_W-1:0]    w_reg;
    logic [PROD1_W-1:0]         prod1_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [EXPL_W-1:0]          explore_reg;
    logic signed [SCORE_W-1:0]  exploit_reg;
    logic signed [SCORE_W-1:0]  score;

    logic [IDX_W-1:0]   pend_child_reg;
    logic [1:0]         pend_status_reg;
    logic               out_valid_reg;
    logic [IDX_W-1:0]   out_child_reg;
    logic [1:0]         out_status_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic               accept;
    logic               idx_in_range;
    logic               req_in_range;
    logic               scan_last;
    logic [VISIT_W-1:0] row_visits;
    logic signed [SUM_W-1:0] row_sum;
    logic signed [SUM_W+1:0] w4;
    logic [DIV_NUM_W-1:0]    w4_abs;
    logic signed [SUM_W+1:0] sum_calc;
    logic signed [SUM_W-1:0] sum_sat;
    logic [VISIT_W-1:0]      visits_inc;
    logic signed [SCORE_W-1:0] div2_val;

    puct_divu u_divu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept       = request.valid && request.ready;
    assign request.ready = (state_reg == ST_IDLE);
    assign cfg.ready    = 1'b1;
    assign idx_in_range = ({1'b0, idx_reg} < (IDX_W + 1)'(NUM_CHILDREN));
    assign req_in_range = ({1'b0, request.child_index} < (IDX_W + 1)'(NUM_CHILDREN));
    assign scan_last    = (scan_reg == CW'(NUM_CHILDREN - 1));

    assign row_visits = row_vq_reg ? row_q_reg[ROW_W-1:SUM_W] : '0;
    assign row_sum    = row_vq_reg ? row_q_reg[SUM_W-1:0] : '0;
    assign visits_inc = (row_visits == VISIT_MAX) ? row_visits : row_visits + 1'b1;

    assign w4     = {w_reg, 2'b00};
    assign w4_abs = w4[SUM_W+1] ? DIV_NUM_W'(-w4) : DIV_NUM_W'(w4);
    assign score  = exploit_reg + $signed({{(SCORE_W - EXPL_W){1'b0}}, explore_reg});

    always_comb
    begin
        if (div_rsp.rem != '0)
            div2_val = -($signed({2'b00, div_rsp.quo}) + SCORE_W'(1));
        else
            div2_val = -$signed({2'b00, div_rsp.quo});
        if (!w4[SUM_W+1])
            div2_val = $signed({2'b00, div_rsp.quo});
    end

    always_comb
    begin
        if (state_reg == ST_BP_WR)
            sum_calc = (SUM_W + 2)'(row_sum) + (SUM_W + 2)'(leaf_reg)
                       + (SUM_W + 2)'(ONE_Q14);
        else
            sum_calc = (SUM_W + 2)'(row_sum) - (SUM_W + 2)'(ONE_Q14);
        if (sum_calc > (SUM_W + 2)'(signed'(32'h7FFF_FFFF)))
            sum_sat = 32'sh7FFF_FFFF;
        else if (sum_calc < -(SUM_W + 2)'(signed'(34'sh0_8000_0000)))
            sum_sat = 32'sh8000_0000;
        else
            sum_sat = sum_calc[SUM_W-1:0];
    end

    always_comb
    begin
        sq_rem_sh = {sq_rem_reg, sq_x_reg[X_W-1:X_W-2]};
        sq_trial  = {2'b00, sq_res_reg, 2'b01};
        if (sq_rem_sh >= sq_trial)
        begin
            sq_rem_next = (SQRT_W + 2)'(sq_rem_sh - sq_trial);
            sq_res_next = {sq_res_reg[SQRT_W-2:0], 1'b1};
        end
        else
        begin
            sq_rem_next = sq_rem_sh[SQRT_W+1:0];
            sq_res_next = {sq_res_reg[SQRT_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_BP_RD:  rd_addr = idx_reg[CW-1:0];
            ST_UPD_RD: rd_addr = best_reg;
            default:   rd_addr = scan_reg;
        endcase
    end

    always_comb
    begin
        row_we = 1'b0;
        row_wa = best_reg;
        row_wd = {visits_inc, sum_sat};
        if (state_reg == ST_BP_WR && idx_in_range)
        begin
            row_we = 1'b1;
            row_wa = idx_reg[CW-1:0];
            row_wd = {row_visits, sum_sat};
        end
        else if (state_reg == ST_UPD_WR)
            row_we = 1'b1;
    end

    assign prior_we = accept && request.cmd == CMD_LOAD && !expanded_reg && req_in_range;

    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = {{(DIV_NUM_W - EXPL_W){1'b0}}, prod_reg[PROD_W-1:28]};
        div_req.den   = {1'b0, n_reg} + 1'b1;
        if (state_reg == ST_DIV1_GO)
            div_req.start = 1'b1;
        else if (state_reg == ST_DIV2_GO)
        begin
            div_req.start = 1'b1;
            div_req.num   = w4_abs;
            div_req.den   = {1'b0, n_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[row_wa] <= row_wd;
        row_q_reg <= row_mem[rd_addr];
        if (prior_we)
            prior_mem[request.child_index[CW-1:0]] <= request.prior_value;
        prior_q_reg <= prior_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (request.cmd)
                        CMD_SELECT:
                        begin
                            if (expanded_reg && request.valid_mask[NUM_CHILDREN-1:0] != '0)
                                state_next = ST_SQRT;
                            else
                                state_next = ST_FINISH;
                        end
                        CMD_BACKUP: state_next = ST_BP_RD;
                        default:    state_next = ST_FINISH;
                    endcase
                end
            end
            ST_BP_RD:   state_next = ST_BP_WR;
            ST_BP_WR:   state_next = ST_FINISH;
            ST_SQRT:
            begin
                if (sq_cnt_reg == SQ_CNT_W'(SQRT_W - 1))
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (mask_reg[scan_reg])
                    state_next = ST_FETCH;
                else if (scan_last)
                    state_next = ST_UPD_RD;
            end
            ST_FETCH:   state_next = ST_MUL;
            ST_MUL:     state_next = ST_DIV1_GO;
            ST_DIV1_GO: state_next = ST_DIV1;
            ST_DIV1:
            begin
                if (div_rsp.done)
                    state_next = (n_reg == '0) ? ST_SCORE : ST_DIV2_GO;
            end
            ST_DIV2_GO: state_next = ST_DIV2;
            ST_DIV2:
            begin
                if (div_rsp.done)
                    state_next = ST_SCORE;
            end
            ST_SCORE:   state_next = scan_last ? ST_UPD_RD : ST_SCAN;
            ST_UPD_RD:  state_next = ST_UPD_WR;
            ST_UPD_WR:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gain_reg      <= GAIN_RESET;
            expanded_reg  <= 1'b0;
            nv_reg        <= '0;
            row_valid_reg <= '0;
            row_vq_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            row_vq_reg <= row_valid_reg[rd_addr];
            if (cfg.valid)
                gain_reg <= cfg.exploration_gain;
            if (row_we)
                row_valid_reg[row_wa] <= 1'b1;
            if (accept && request.cmd == CMD_LOAD && !expanded_reg && request.prior_last)
            begin
                expanded_reg <= 1'b1;
                nv_reg       <= '0;
            end
            if (state_reg == ST_UPD_WR && nv_reg != NODE_MAX)
                nv_reg <= nv_reg + 1'b1;
            if (state_reg == ST_SQRT)
                found_reg <= 1'b0;
            else if (state_reg == ST_SCORE && (!found_reg || score > best_score_reg))
                found_reg <= 1'b1;
            if (state_reg == ST_FINISH && (!out_valid_reg || result.ready))
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg         <= request.child_index;
            leaf_reg        <= request.leaf_value;
            mask_reg        <= request.valid_mask[NUM_CHILDREN-1:0];
            sq_x_reg        <= {nv_reg, 32'd0};
            sq_rem_reg      <= '0;
            sq_res_reg      <= '0;
            sq_cnt_reg      <= '0;
            scan_reg        <= '0;
            pend_child_reg  <= '0;
            pend_status_reg <= STATUS_OK;
            if (request.cmd == CMD_SELECT)
            begin
                if (!expanded_reg)
                    pend_status_reg <= STATUS_NOT_EXP;
                else if (request.valid_mask[NUM_CHILDREN-1:0] == '0)
                    pend_status_reg <= STATUS_NO_VALID;
            end
        end
        if (state_reg == ST_SQRT)
        begin
            sq_x_reg   <= {sq_x_reg[X_W-3:0], 2'b00};
            sq_rem_reg <= sq_rem_next;
            sq_res_reg <= sq_res_next;
            sq_cnt_reg <= sq_cnt_reg + 1'b1;
            s_reg      <= (nv_reg == '0) ? SQRT_ZERO : sq_res_next;
        end
        if (state_reg == ST_SCAN && !mask_reg[scan_reg] && !scan_last)
            scan_reg <= scan_reg + 1'b1;
        if (state_reg == ST_FETCH)
        begin
            n_reg     <= row_visits;
            w_reg     <= row_sum;
            prod1_reg <= gain_reg * prior_q_reg;
        end
        if (state_reg == ST_MUL)
            prod_reg <= prod1_reg * s_reg;
        if (state_reg == ST_DIV1 && div_rsp.done)
        begin
            explore_reg <= div_rsp.quo[EXPL_W-1:0];
            exploit_reg <= '0;
        end
        if (state_reg == ST_DIV2 && div_rsp.done)
            exploit_reg <= div2_val;
        if (state_reg == ST_SCORE)
        begin
            if (!found_reg || score > best_score_reg)
            begin
                best_score_reg <= score;
                best_reg       <= scan_reg;
            end
            if (!scan_last)
                scan_reg <= scan_reg + 1'b1;
        end
        if (state_reg == ST_UPD_WR)
            pend_child_reg <= IDX_W'(best_reg);
        if (state_reg == ST_FINISH && (!out_valid_reg || result.ready))
        begin
            out_child_reg  <= pend_child_reg;
            out_status_reg <= pend_status_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.chosen_child = out_child_reg;
    assign result.status       = out_status_reg;

`ifndef SYNTHESIS
    a_err_no_child: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status != STATUS_OK |-> result.chosen_child == '0)
        else $error("error result carries a child index");

    a_node_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> nv_reg == $past(nv_reg) || nv_reg == $past(nv_reg) + 1'b1 || nv_reg == '0)
        else $error("node visit count jumped");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !request.ready)
        else $error("second request taken while one is in work");
`endif

endmodule

FILE: dv/puct_child_selector_tb.sv
// testbench of the puct child selector: directed and random command streams,
// results checked against an internal scoring model of the node
// depends on puct_pkg, puct_if and the puct_child_selector rtl
`timescale 1ns / 1ps

module tb;
    import puct_pkg::*;

    localparam int NCH = NUM_CHILDREN_DEF;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  idx;
        logic [15:0] prior;
        logic        last;
        logic [15:0] leaf;
        logic [63:0] mask;
    } node_cmd_t;

    typedef struct packed {
        logic [5:0] chosen;
        logic [1:0] status;
    } selection_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    puct_cfg_if cfg ();
    puct_req_if request ();
    puct_rsp_if result ();

    puct_child_selector dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg.sink),
        .request (request.sink),
        .result  (result.source)
    );

    logic [19:0]        visits_m [NCH];
    logic signed [31:0] wsum_m [NCH];
    logic [15:0]        prior_m [NCH];
    logic [25:0]        node_n_m;
    logic               expanded_m;
    logic [15:0]        gain_m;

    selection_t expected_sel[$];
    int errors = 0;
    int idle_cycles = 0;
    bit long_stalls = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint floor_quot(input longint num, input longint den);
        if (num >= 0) return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function automatic logic signed [31:0] sat_sum(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic selection_t predict_selection(input node_cmd_t c);
        selection_t r;
        logic [63:0] s;
        logic [63:0] prod;
        longint n, score, best, explore, exploit;
        int best_a;
        bit found;
        r = '0;
        if (c.cmd == CMD_LOAD)
        begin
            if (!expanded_m)
            begin
                prior_m[c.idx] = c.prior;
                if (c.last)
                begin
                    expanded_m = 1'b1;
                    node_n_m = '0;
                end
            end
        end
        else if (c.cmd == CMD_SELECT)
        begin
            if (!expanded_m)
                r.status = STATUS_NOT_EXP;
            else
            begin
                s = node_n_m == 0 ? 64'd7 : isqrt({6'd0, node_n_m, 32'd0});
                found = 0;
                best = 0;
                best_a = 0;
                for (int a = 0; a < NCH; a++)
                begin
                    if (!c.mask[a]) continue;
                    n = visits_m[a];
                    prod = 64'(gain_m) * 64'(prior_m[a]) * s;
                    explore = longint'((prod / 64'(n + 1)) >> 28);
                    exploit = n == 0 ? 0 : floor_quot(longint'(wsum_m[a]) * 4, n);
                    score = exploit + explore;
                    if (!found || score > best)
                    begin
                        found = 1;
                        best = score;
                        best_a = a;
                    end
                end
                if (!found)
                    r.status = STATUS_NO_VALID;
                else
                begin
                    r.chosen = best_a[5:0];
                    r.status = STATUS_OK;
                    if (visits_m[best_a] != VISIT_MAX) visits_m[best_a]++;
                    if (node_n_m != NODE_MAX) node_n_m++;
                    wsum_m[best_a] = sat_sum(longint'(wsum_m[best_a]) - ONE_Q14);
                end
            end
        end
        else if (c.cmd == CMD_BACKUP)
            wsum_m[c.idx] = sat_sum(longint'(wsum_m[c.idx])
                                    + longint'($signed(c.leaf)) + ONE_Q14);
        return r;
    endfunction

    function automatic int random_gap();
        if (long_stalls && $urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // model reset and port defaults
    initial
    begin
        for (int i = 0; i < NCH; i++)
        begin
            visits_m[i] = '0;
            wsum_m[i] = '0;
            prior_m[i] = '0;
        end
        node_n_m = '0;
        expanded_m = 1'b0;
        gain_m = GAIN_RESET;
        cfg.valid <= 1'b0;
        cfg.exploration_gain <= '0;
        request.valid <= 1'b0;
        request.cmd <= '0;
        request.child_index <= '0;
        request.prior_value <= '0;
        request.prior_last <= 1'b0;
        request.leaf_value <= '0;
        request.valid_mask <= '0;
    end

    // the request is dropped at its transfer edge and the task waits for a further edge,
    // so it is never driven twice in one time step
    task automatic send_cmd(input node_cmd_t c);
        int g;
        g = random_gap();
        repeat (g) @(posedge clk);
        request.valid <= 1'b1;
        request.cmd <= c.cmd;
        request.child_index <= c.idx;
        request.prior_value <= c.prior;
        request.prior_last <= c.last;
        request.leaf_value <= c.leaf;
        request.valid_mask <= c.mask;
        do @(posedge clk); while (!request.ready);
        expected_sel.push_back(predict_selection(c));
        request.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_sel.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_gain(input logic [15:0] g);
        wait_drained();
        cfg.valid <= 1'b1;
        cfg.exploration_gain <= g;
        do @(posedge clk); while (!cfg.ready);
        gain_m = g;
        cfg.valid <= 1'b0;
    endtask

    function automatic node_cmd_t make_cmd(input logic [1:0] cmd, input int idx,
                                            input logic [15:0] prior, input bit last,
                                            input logic [15:0] leaf,
                                            input logic [63:0] mask);
        node_cmd_t c;
        c.cmd = cmd;
        c.idx = idx[5:0];
        c.prior = prior;
        c.last = last;
        c.leaf = leaf;
        c.mask = mask;
        return c;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic node_cmd_t noise_cmd();
        return make_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 63), 16'($urandom()),
                        1'($urandom_range(0, 1)), 16'($urandom()), rand64());
    endfunction

    task automatic test_directed();
        send_cmd(make_cmd(CMD_SELECT, 0, 0, 0, 0, '1));
        send_cmd(make_cmd(CMD_BACKUP, 63, 0, 0, 16'sh4000, '0));
        send_cmd(make_cmd(CMD_BACKUP, 0, 0, 0, 16'shc000, '0));
        send_cmd(make_cmd(2'd3, 5, 16'hffff, 1, 16'h8000, '1));
        for (int i = 0; i < NCH; i++)
            send_cmd(make_cmd(CMD_LOAD, i,
                              i == 63 ? 16'hffff : (i == 0 ? 16'h0 : 16'($urandom())),
                              i == NCH - 1, 0, '0));
        send_cmd(make_cmd(CMD_LOAD, 3, 16'h1234, 1, 0, '0));
        send_cmd(make_cmd(CMD_SELECT, 0, 0, 0, 0, '0));
        send_cmd(make_cmd(CMD_SELECT, 0, 0, 0, 0, '1));
        send_cmd(make_cmd(CMD_SELECT, 0, 0, 0, 0, 64'h1));
        send_cmd(make_cmd(CMD_SELECT, 0, 0, 0, 0, 64'h8000000000000001));
        send_cmd(make_cmd(CMD_BACKUP, 0, 0, 0, 16'h7fff, '0));
        send_cmd(make_cmd(CMD_BACKUP, 63, 0, 0, 16'h8000, '0));
        send_cmd(make_cmd(CMD_SELECT, 0, 0, 0, 0, 64'h3));
    endtask

    // one expansion: priors for all children if the node is not yet expanded, then a stream of searches
    task automatic run_episode(input int n_items, input logic [63:0] focus);
        node_cmd_t c;
        int kind;
        if (!expanded_m)
            for (int i = 0; i < NCH; i++)
                send_cmd(make_cmd(CMD_LOAD, i, 16'($urandom()), i == NCH - 1, 0, '0));
        for (int k = 0; k < n_items; k++)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 10)
                c = make_cmd(CMD_SELECT, $urandom_range(0, 63), 16'($urandom()),
                             1'($urandom_range(0, 1)), 16'($urandom()),
                             ($urandom_range(0, 3) == 0) ? rand64() : focus);
            else if (kind < 17)
                c = make_cmd(CMD_BACKUP, $urandom_range(0, 63), 16'($urandom()),
                             1'($urandom_range(0, 1)),
                             $urandom_range(0, 1) ? 16'($signed($urandom_range(0, 32768)) - 16384)
                                                  : 16'($urandom()), '0);
            else
                c = noise_cmd();
            if (kind == 5 && $urandom_range(0, 3) == 0) c.mask = '0;
            send_cmd(c);
        end
    endtask

    task automatic test_gain_extremes();
        write_gain(16'd0);
        run_episode(150, 64'hff);
        write_gain(16'hffff);
        run_episode(150, rand64());
        write_gain(16'd1);
        run_episode(100, 64'h0f0f);
    endtask

    task automatic test_random_search();
        for (int p = 0; p < 6; p++)
        begin
            write_gain(16'($urandom()));
            long_stalls = p[0];
            run_episode(230, rand64() & {$urandom_range(0, 1) ? 32'hffffffff : 32'h0, 32'hffffffff});
        end
    endtask

    task automatic test_drain_pause();
        run_episode(20, 64'h3c);
        wait_drained();
        run_episode(20, 64'h3c);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            result.ready <= (long_stalls && $urandom_range(0, 9) == 0) ? 1'b0
                            : ($urandom_range(0, 3) != 0);
        else
            result.ready <= 1'b0;
    end

    always @(posedge clk)
    begin
        selection_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_sel.size() == 0)
            begin
                $display("%0t unexpected transfer: actual chosen %0d status %0d",
                         $realtime, result.chosen_child, result.status);
                errors++;
            end
            else
            begin
                want = expected_sel.pop_front();
                if (want.chosen !== result.chosen_child || want.status !== result.status)
                begin
                    $display("%0t expected chosen %0d status %0d, actual chosen %0d status %0d",
                             $realtime, want.chosen, want.status,
                             result.chosen_child, result.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((request.valid && request.ready) || (result.valid && result.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("puct_child_selector: mismatch");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_gain_extremes();
        test_drain_pause();
        test_random_search();
        wait_drained();
        repeat (100) @(posedge clk);
        if (errors == 0 && expected_sel.size() == 0)
            $display("puct_child_selector: match");
        else
            $display("puct_child_selector: mismatch");
        $finish;
    end
endmodule
